>>> rtl/core/bmhq_pkg.sv
// bmhq_pkg: shared types and constants of the binary min-heap queue.
// No dependencies; bmhq_if, bmhq_seq, binary_min_heap_queue and bmhq_chk import it.
`default_nettype none

package bmhq_pkg;

	// entry count, position and capacity limit width
	localparam int CNT_W = 11;

	localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd1024;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// result side info, sequencer to output stage
	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] count;
	} res_info_t;

endpackage

`default_nettype wire

>>> rtl/core/bmhq_if.sv
// bmhq_cmd_if / bmhq_rsp_if: valid/ready channels of the heap queue.
// Depends on bmhq_pkg for the count width.
`default_nettype none

interface bmhq_cmd_if #(
	parameter int KEY_WIDTH  = 32,
	parameter int ATTR_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [KEY_WIDTH-1:0]  key;
	logic [ATTR_WIDTH-1:0] attr;

	modport source (output valid, output cmd, output key, output attr, input ready);
	modport sink   (input valid, input cmd, input key, input attr, output ready);
endinterface

interface bmhq_rsp_if #(
	parameter int ATTR_WIDTH = 32
);
	import bmhq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [ATTR_WIDTH-1:0] min_attr;
	logic [CNT_W-1:0]      count;

	modport source (output valid, output status, output min_attr, output count, input ready);
	modport sink   (input valid, input status, input min_attr, input count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bmhq_ram.sv
// bmhq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bmhq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bmhq_seq.sv
// bmhq_seq: insert / pop sequencer; sifts entries through the heap RAM.
// Depends on bmhq_pkg and bmhq_cmd_if; drives the ports of one bmhq_ram.
`default_nettype none

module bmhq_seq #(
	parameter int DEPTH      = 1024,
	parameter int KEY_WIDTH  = 32,
	parameter int ATTR_WIDTH = 32,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int EW        = KEY_WIDTH + ATTR_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bmhq_cmd_if.sink                        req,
	input  wire logic [bmhq_pkg::CNT_W-1:0] cap_limit,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output bmhq_pkg::res_info_t             res_info,
	output logic [ATTR_WIDTH-1:0]           res_attr,
	output logic                            mem_we,
	output logic [AW-1:0]                   mem_waddr,
	output logic [EW-1:0]                   mem_wdata,
	output logic                            mem_re,
	output logic [AW-1:0]                   mem_raddr,
	input  wire logic [EW-1:0]              mem_rdata
);

	import bmhq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_I_RD,   // issue parent read, or place new entry at root
		S_I_CMP,  // parent data back: move parent down or place new entry
		S_P_ROOT, // issue root read
		S_P_LAST, // root back; issue read of last entry
		S_P_LD,   // last entry back
		S_P_RDL,  // issue left child read, or place last entry
		S_P_RDR,  // left back; issue right child read
		S_P_CMP,  // right back; pick smaller child and compare
		S_DONE
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      pos_q;
	logic [EW-1:0]         new_q;
	logic [EW-1:0]         last_q;
	logic [EW-1:0]         left_q;
	logic                  has_r_q;
	status_t               status_q;
	logic [ATTR_WIDTH-1:0] attr_q;

	logic [CNT_W:0]  child;
	logic [CNT_W:0]  n_ext;
	logic            pick_r;
	logic [EW-1:0]   pick;
	logic            new_lt_par;
	logic            pick_lt_last;

	function automatic logic [AW-1:0] pos_addr(input logic [CNT_W:0] p);
		return AW'(p - 1'b1);
	endfunction

	function automatic logic [KEY_WIDTH-1:0] ekey(input logic [EW-1:0] e);
		return e[EW-1:ATTR_WIDTH];
	endfunction

	assign child        = {pos_q, 1'b0};
	assign n_ext        = {1'b0, cnt_q};
	assign pick_r       = has_r_q && (ekey(mem_rdata) < ekey(left_q));
	assign pick         = pick_r ? mem_rdata : left_q;
	assign pick_lt_last = ekey(pick) < ekey(last_q);
	assign new_lt_par   = ekey(new_q) < ekey(mem_rdata);

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_info  = '{status: status_q, count: cnt_q};
	assign res_attr  = attr_q;

	// RAM port control; reads never target an entry written earlier in the same op
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_addr({1'b0, pos_q});
		mem_wdata = last_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_I_RD: begin
				if (pos_q == CNT_W'(1)) begin
					mem_we    = 1'b1;
					mem_wdata = new_q;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = pos_addr({2'b00, pos_q[CNT_W-1:1]});
				end
			end
			S_I_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = new_lt_par ? mem_rdata : new_q;
			end
			S_P_ROOT: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
			end
			S_P_LAST: begin
				// cnt_q already holds count-1, i.e. the last entry's address
				mem_re    = 1'b1;
				mem_raddr = AW'(cnt_q);
			end
			S_P_RDL: begin
				if (child > n_ext) begin
					mem_we = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = pos_addr(child);
				end
			end
			S_P_RDR: begin
				mem_re    = (child < n_ext);
				mem_raddr = AW'(child);
			end
			S_P_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = pick_lt_last ? pick : last_q;
			end
			S_IDLE, S_P_LD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			pos_q    <= '0;
			new_q    <= '0;
			last_q   <= '0;
			left_q   <= '0;
			has_r_q  <= 1'b0;
			status_q <= ST_OK;
			attr_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						new_q    <= {req.key, req.attr};
						status_q <= ST_OK;
						attr_q   <= '0;
						if (req.cmd == CMD_INSERT) begin
							if (cnt_q < cap_limit) begin
								pos_q   <= cnt_q + CNT_W'(1);
								cnt_q   <= cnt_q + CNT_W'(1);
								state_q <= S_I_RD;
							end else begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end
						end else begin
							if (cnt_q != '0) begin
								cnt_q   <= cnt_q - CNT_W'(1);
								state_q <= S_P_ROOT;
							end else begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end
						end
					end
				end
				S_I_RD: begin
					state_q <= (pos_q == CNT_W'(1)) ? S_DONE : S_I_CMP;
				end
				S_I_CMP: begin
					if (new_lt_par) begin
						pos_q   <= pos_q >> 1;
						state_q <= S_I_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_P_ROOT: begin
					state_q <= S_P_LAST;
				end
				S_P_LAST: begin
					attr_q  <= mem_rdata[ATTR_WIDTH-1:0];
					state_q <= S_P_LD;
				end
				S_P_LD: begin
					last_q  <= mem_rdata;
					pos_q   <= CNT_W'(1);
					state_q <= (cnt_q == '0) ? S_DONE : S_P_RDL;
				end
				S_P_RDL: begin
					state_q <= (child > n_ext) ? S_DONE : S_P_RDR;
				end
				S_P_RDR: begin
					left_q  <= mem_rdata;
					has_r_q <= (child < n_ext);
					state_q <= S_P_CMP;
				end
				S_P_CMP: begin
					if (pick_lt_last) begin
						pos_q   <= CNT_W'(child) | CNT_W'(pick_r);
						state_q <= S_P_RDL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/binary_min_heap_queue.sv
// binary_min_heap_queue: top level of the min-heap priority queue.
// Depends on bmhq_pkg, bmhq_if, bmhq_ram and bmhq_seq.
//
// A priority queue of (key, attr) entries kept as a one-based binary min-heap in a
// single RAM of DEPTH entries (registered read, one read and one write port). Each
// req beat either inserts (cmd 0) or pops the smallest key (cmd 1); each produces
// exactly one rsp beat with status (0 ok, 1 insert refused because the queue is at
// its limit, 2 pop on an empty queue), min_attr (popped attribute, else 0) and the
// entry count after the operation. Equal keys: an insert stops below an equal
// parent, a pop prefers the left child on a tie. The limit is max_entries
// (cfg_we/cfg_wdata, reset 1024), saturated at DEPTH; lowering it below the
// current count only refuses inserts. Write it only while idle. One item is in
// work at a time; timing is set by the single RAM read port, one read per cycle
// with a registered result. An insert reads the parent and compares for each
// level moved, and writes the new entry at the root when it gets there; a pop
// reads the root, then the last entry, then for each level the left and the
// right child through the same port before it compares. The rsp side has its
// own output register, so the next req beat is taken while a result waits. The
// RAM needs no clearing; only written positions are ever read.
`default_nettype none

module binary_min_heap_queue #(
	parameter int DEPTH      = 1024,
	parameter int KEY_WIDTH  = 32,
	parameter int ATTR_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bmhq_cmd_if.sink                        req,
	bmhq_rsp_if.source                      rsp,
	input  wire logic                       cfg_we,
	input  wire logic [bmhq_pkg::CNT_W-1:0] cfg_wdata
);

	import bmhq_pkg::*;

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW      = KEY_WIDTH + ATTR_WIDTH;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	// deepest position the 11-bit limit can ever reach
	localparam int CAP_MAX = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

	logic [CNT_W-1:0] max_entries_q;
	logic [CNT_W-1:0] cap_limit;

	// sequencer result side
	logic                  res_valid;
	logic                  res_ready;
	res_info_t             res_info;
	logic [ATTR_WIDTH-1:0] res_attr;

	// output register
	logic                  out_valid_q;
	res_info_t             out_info_q;
	logic [ATTR_WIDTH-1:0] out_attr_q;

	// heap RAM ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	// limit in use: max_entries saturated at the RAM depth
	assign cap_limit = (max_entries_q > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : max_entries_q;

	bmhq_seq #(
		.DEPTH      (DEPTH),
		.KEY_WIDTH  (KEY_WIDTH),
		.ATTR_WIDTH (ATTR_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cap_limit (cap_limit),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_info  (res_info),
		.res_attr  (res_attr),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bmhq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: loads when empty or when its beat leaves this cycle
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_info_q <= res_info;
			out_attr_q <= res_attr;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_info_q.status;
	assign rsp.count    = out_info_q.count;
	assign rsp.min_attr = out_attr_q;

endmodule

`default_nettype wire

>>> rtl/core/bmhq_chk.sv
// bmhq_chk: port-level checks of binary_min_heap_queue, with its bind.
// Depends on bmhq_pkg; sees only the top level's ports.
`default_nettype none

module bmhq_chk #(
	parameter int ATTR_WIDTH = 32
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [1:0]                 rsp_status,
	input wire logic [ATTR_WIDTH-1:0]      rsp_min_attr,
	input wire logic [bmhq_pkg::CNT_W-1:0] rsp_count
);

	import bmhq_pkg::*;

	logic             have_prev_q;
	logic [CNT_W-1:0] prev_cnt_q;
	logic             rsp_beat;

	assign rsp_beat = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_cnt_q  <= '0;
		end else if (rsp_beat) begin
			have_prev_q <= 1'b1;
			prev_cnt_q  <= rsp_count;
		end
	end

	// a waiting result holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_min_attr) && $stable(rsp_count))
		else $error("rsp beat changed while stalled");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_min_attr == '0) && (rsp_count == '0))
		else $error("empty pop with nonzero attr or count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_FULL)
			|| (rsp_status == ST_EMPTY))
		else $error("undefined status code");

	// a refused insert leaves the count alone
	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_beat && have_prev_q && (rsp_status == ST_FULL) |-> rsp_count == prev_cnt_q)
		else $error("refused insert changed the count");

	// a served op moves the count by exactly one
	a_ok_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_beat && have_prev_q && (rsp_status == ST_OK)
			|-> (rsp_count == prev_cnt_q + CNT_W'(1)) || (rsp_count == prev_cnt_q - CNT_W'(1)))
		else $error("served op did not move the count by one");

endmodule

bind binary_min_heap_queue bmhq_chk #(
	.ATTR_WIDTH (ATTR_WIDTH)
) u_bmhq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_min_attr (rsp.min_attr),
	.rsp_count    (rsp.count)
);

`default_nettype wire
